// File: hdl/ip_egress_address_blocker_assert.svh
// assertion macros for the egress address blocker
// expects i_clk and i_rst_n in the scope of the module that uses them
`ifndef IP_EGRESS_ADDRESS_BLOCKER_ASSERT_SVH
`define IP_EGRESS_ADDRESS_BLOCKER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define IPEAB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define IPEAB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/ipeab_pkg.sv
// shared types, prefix tables and classifier functions for the egress address blocker
// no dependencies
package ipeab_pkg;

    typedef enum logic [2:0] {
        CAT_PUBLIC   = 3'd0,
        CAT_NULL     = 3'd1,
        CAT_LOOPBACK = 3'd2,
        CAT_CASTING  = 3'd3,
        CAT_UNSPEC   = 3'd4,
        CAT_LOCAL    = 3'd5,
        CAT_SPECIAL  = 3'd6
    } t_category;

    localparam int unsigned V4_SPECIAL_COUNT = 11;

    typedef logic [31:0] t_v4_table [V4_SPECIAL_COUNT];

    localparam t_v4_table V4_SPECIAL_NET = '{
        32'h0000_0000, 32'h0A00_0000, 32'h6440_0000, 32'hAC10_0000, 32'hC000_0000,
        32'hC000_0200, 32'hC0A8_0000, 32'hC612_0000, 32'hC633_6400, 32'hCB00_7100,
        32'hF000_0000
    };

    localparam t_v4_table V4_SPECIAL_MASK = '{
        32'hFF00_0000, 32'hFF00_0000, 32'hFFC0_0000, 32'hFFF0_0000, 32'hFFFF_FF00,
        32'hFFFF_FF00, 32'hFFFF_0000, 32'hFFFE_0000, 32'hFFFF_FF00, 32'hFFFF_FF00,
        32'hF000_0000
    };

    localparam logic [63:0] NAT64_HIGH   = 64'h0064_FF9B_0000_0000;
    localparam logic [63:0] DISCARD_HIGH = 64'h0100_0000_0000_0000;
    localparam logic [31:0] TEREDO_TOP   = 32'h2001_0000;
    localparam logic [31:0] DOC_TOP      = 32'h2001_0DB8;
    localparam logic [15:0] SIX_TO_FOUR  = 16'h2002;
    localparam logic [15:0] MAPPED_MARK  = 16'hFFFF;

    function automatic t_category classify_v4(input logic [31:0] a);
        logic special;
        t_category cat;
        special = 1'b0;
        for (int i = 0; i < V4_SPECIAL_COUNT; i++) begin
            if ((a & V4_SPECIAL_MASK[i]) == V4_SPECIAL_NET[i]) begin
                special = 1'b1;
            end
        end
        if (a[31:24] == 8'h7F) begin
            cat = CAT_LOOPBACK;
        end else if (a == 32'hFFFF_FFFF || a[31:28] == 4'hE) begin
            cat = CAT_CASTING;
        end else if (a == 32'h0) begin
            cat = CAT_UNSPEC;
        end else if (a[31:16] == 16'hA9FE) begin
            cat = CAT_LOCAL;
        end else if (special) begin
            cat = CAT_SPECIAL;
        end else begin
            cat = CAT_PUBLIC;
        end
        return cat;
    endfunction

    function automatic t_category classify_v6(input logic [63:0] hi, input logic [63:0] lo);
        t_category cat_6to4;
        t_category cat_teredo;
        t_category cat_nat64;
        t_category cat;
        cat_6to4   = classify_v4(hi[47:16]);
        cat_teredo = classify_v4(~lo[31:0]);
        cat_nat64  = classify_v4(lo[31:0]);
        if (hi == 64'h0 && lo == 64'h1) begin
            cat = CAT_LOOPBACK;
        end else if (hi[63:56] == 8'hFF) begin
            cat = CAT_CASTING;
        end else if (hi == 64'h0 && lo == 64'h0) begin
            cat = CAT_UNSPEC;
        // fe80::/10, fec0::/10, fc00::/7
        end else if (hi[63:54] == 10'h3FA || hi[63:54] == 10'h3FB || hi[63:57] == 7'h7E) begin
            cat = CAT_LOCAL;
        end else if (hi[63:48] == SIX_TO_FOUR) begin
            cat = cat_6to4;
        end else if (hi[63:32] == TEREDO_TOP) begin
            cat = cat_teredo;
        end else if (hi == NAT64_HIGH && lo[63:32] == 32'h0) begin
            cat = cat_nat64;
        end else if (hi == DISCARD_HIGH || hi[63:32] == DOC_TOP) begin
            cat = CAT_SPECIAL;
        end else begin
            cat = CAT_PUBLIC;
        end
        return cat;
    endfunction

endpackage

// File: hdl/ip_egress_address_blocker.sv
// Egress address blocker: one IPv4 or IPv6 destination word per cycle goes in, one verdict
// word (blocked flag and category) comes out per accepted address word, through the input
// and output registers. The address is held in an input register, classified by parallel prefix
// compares, and the verdict lands in an output register, so the sustained rate is one word
// per clock, limited only by downstream stall.
// A stalled output holds the input register only once that register is full as well.
// The allow_loopback register is written through the cfg port, which is always ready; write
// it only while no word is in flight.
// depends on ipeab_pkg and ip_egress_address_blocker_assert.svh
module ip_egress_address_blocker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_allow_loopback,
    // address words
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_addr_high,
    input  logic [63:0] i_addr_low,
    input  logic        i_is_ipv6,
    input  logic        i_is_null,
    // verdict words
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_blocked,
    output logic [2:0]  o_category
);
    import ipeab_pkg::*;

    `include "ip_egress_address_blocker_assert.svh"

    logic        r_allow_loopback;
    logic        r_s1_valid;
    logic [63:0] r_s1_addr_high;
    logic [63:0] r_s1_addr_low;
    logic        r_s1_is_ipv6;
    logic        r_s1_is_null;
    logic        r_out_valid;
    logic        r_out_blocked;
    t_category   r_out_category;

    logic        advance;
    logic        in_accept;
    t_category   n_category;
    logic        n_blocked;

    assign o_cfg_ready = 1'b1;

    // output register frees up when empty or taken this cycle
    assign advance   = !r_out_valid || !i_stall;
    assign o_stall   = r_s1_valid && !advance;
    assign in_accept = i_valid && !o_stall;

    always_comb begin
        if (r_s1_is_null) begin
            n_category = CAT_NULL;
        end else if (!r_s1_is_ipv6) begin
            n_category = classify_v4(r_s1_addr_low[31:0]);
        end else if (r_s1_addr_high == 64'h0 && r_s1_addr_low[63:32] == {16'h0, MAPPED_MARK}) begin
            // ipv4-mapped ipv6 is judged as plain ipv4
            n_category = classify_v4(r_s1_addr_low[31:0]);
        end else begin
            n_category = classify_v6(r_s1_addr_high, r_s1_addr_low);
        end
    end

    always_comb begin
        case (n_category)
            CAT_PUBLIC:   n_blocked = 1'b0;
            CAT_LOOPBACK: n_blocked = !r_allow_loopback;
            default:      n_blocked = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow_loopback <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_allow_loopback <= i_cfg_allow_loopback;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_stall) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_addr_high <= i_addr_high;
            r_s1_addr_low  <= i_addr_low;
            r_s1_is_ipv6   <= i_is_ipv6;
            r_s1_is_null   <= i_is_null;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            r_out_blocked  <= n_blocked;
            r_out_category <= n_category;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_blocked  = r_out_blocked;
    assign o_category = r_out_category;

    `IPEAB_ASSERT_IMP(a_public_passes, o_valid && o_category == CAT_PUBLIC, !o_blocked,
        "public address reported as blocked")
    `IPEAB_ASSERT_IMP(a_refused_blocked,
        o_valid && o_category != CAT_PUBLIC && o_category != CAT_LOOPBACK, o_blocked,
        "non-public address let through")
    `IPEAB_ASSERT_NXT(a_null_verdict, r_s1_valid && r_s1_is_null && advance,
        o_valid && o_category == CAT_NULL && o_blocked, "null word not refused as null")
    `IPEAB_ASSERT_NXT(a_word_moves, r_s1_valid && advance, o_valid,
        "word lost between input and output register")

endmodule

// File: test/ip_egress_address_blocker_test.sv
`timescale 1ns / 100ps
// self-checking testbench for ip_egress_address_blocker: a directed table, then random words
// under bursty sending and random downstream stall, checked against a local verdict predictor
// depends on ipeab_pkg and the rtl under hdl
module ip_egress_address_blocker_test;
    import ipeab_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DIR_ROWS     = 23;
    localparam int unsigned PHASE_WORDS  = 350;
    localparam logic [15:0] PFX_6TO4     = 16'h2002;
    localparam logic [31:0] PFX_TEREDO   = 32'h2001_0000;
    localparam logic [31:0] PFX_DOC      = 32'h2001_0DB8;
    localparam logic [63:0] PFX_NAT64    = 64'h0064_FF9B_0000_0000;
    localparam logic [63:0] PFX_DISCARD  = 64'h0100_0000_0000_0000;
    localparam logic [31:0] MAPPED_UPPER = 32'h0000_FFFF;
    localparam logic [63:0] ONES64       = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic      blocked;
        t_category cat;
    } t_verdict;

    typedef struct {
        logic [31:0] net;
        int unsigned len;
    } t_v4_prefix;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
        logic        v6;
        logic        nul;
        bit          typed;
        logic        blk;
        t_category   cat;
    } t_dir_row;

    // ipv4 special-use blocks, always refused
    t_v4_prefix v4_reserved [11] = '{
        '{32'h0000_0000, 8},  '{32'h0A00_0000, 8},  '{32'h6440_0000, 10},
        '{32'hAC10_0000, 12}, '{32'hC000_0000, 24}, '{32'hC000_0200, 24},
        '{32'hC0A8_0000, 16}, '{32'hC612_0000, 15}, '{32'hC633_6400, 24},
        '{32'hCB00_7100, 24}, '{32'hF000_0000, 4}
    };

    // loopback, broadcast, multicast, unspecified, link-local
    t_v4_prefix v4_scoped [5] = '{
        '{32'h7F00_0000, 8}, '{32'hFFFF_FFFF, 32}, '{32'hE000_0000, 4},
        '{32'h0000_0000, 32}, '{32'hA9FE_0000, 16}
    };

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{64'h0, 64'h0, 1'b0, 1'b1, 1'b1, 1'b1, CAT_NULL},
        '{ONES64, ONES64, 1'b1, 1'b1, 1'b1, 1'b1, CAT_NULL},
        '{64'h0, 64'h0, 1'b0, 1'b0, 1'b1, 1'b1, CAT_UNSPEC},
        '{ONES64, ONES64, 1'b0, 1'b0, 1'b1, 1'b1, CAT_CASTING},
        '{64'h0, 64'h7F00_0001, 1'b0, 1'b0, 1'b1, 1'b1, CAT_LOOPBACK},
        '{64'h0, 64'h0808_0808, 1'b0, 1'b0, 1'b1, 1'b0, CAT_PUBLIC},
        '{64'h0, 64'hE000_0001, 1'b0, 1'b0, 1'b0, 1'b0, CAT_PUBLIC},
        '{64'h0, 64'hA9FE_0101, 1'b0, 1'b0, 1'b0, 1'b0, CAT_PUBLIC},
        '{64'h0, 64'h0A01_0203, 1'b0, 1'b0, 1'b0, 1'b0, CAT_PUBLIC},
        '{64'h0, 64'h6440_0001, 1'b0, 1'b0, 1'b0, 1'b0, CAT_PUBLIC},
        '{64'h0, 64'h1, 1'b1, 1'b0, 1'b1, 1'b1, CAT_LOOPBACK},
        '{64'h0, 64'h0, 1'b1, 1'b0, 1'b1, 1'b1, CAT_UNSPEC},
        '{64'hFF02_0000_0000_0000, 64'h1, 1'b1, 1'b0, 1'b0, 1'b0, CAT_PUBLIC},
        '{64'hFE80_0000_0000_0000, 64'h1, 1'b1, 1'b0, 1'b0, 1'b0, CAT_PUBLIC},
        '{64'hFEC0_0000_0000_0000, 64'h1, 1'b1, 1'b0, 1'b0, 1'b0, CAT_PUBLIC},
        '{64'hFD00_0000_0000_0000, 64'h1, 1'b1, 1'b0, 1'b0, 1'b0, CAT_PUBLIC},
        '{64'h2002_7F00_0001_0000, 64'h0, 1'b1, 1'b0, 1'b0, 1'b0, CAT_PUBLIC},
        '{64'h2001_0000_4136_E378, 64'h8000_F227_F7F7_F7F7, 1'b1, 1'b0, 1'b0, 1'b0,
          CAT_PUBLIC},
        '{PFX_NAT64, 64'h0000_0000_C0A8_0001, 1'b1, 1'b0, 1'b0, 1'b0, CAT_PUBLIC},
        '{PFX_DISCARD, 64'hDEAD_BEEF, 1'b1, 1'b0, 1'b0, 1'b0, CAT_PUBLIC},
        '{64'h2001_0DB8_0000_0000, 64'h1, 1'b1, 1'b0, 1'b0, 1'b0, CAT_PUBLIC},
        '{64'h0, 64'h0000_FFFF_7F00_0001, 1'b1, 1'b0, 1'b0, 1'b0, CAT_PUBLIC},
        '{64'h2606_4700_0000_0000, 64'h1111, 1'b1, 1'b0, 1'b0, 1'b0, CAT_PUBLIC}
    };

    logic        i_clk                = 1'b0;
    logic        i_rst_n              = 1'b0;
    logic        i_cfg_valid          = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_allow_loopback = 1'b0;
    logic        i_valid              = 1'b0;
    logic        o_stall;
    logic [63:0] i_addr_high          = 64'h0;
    logic [63:0] i_addr_low           = 64'h0;
    logic        i_is_ipv6            = 1'b0;
    logic        i_is_null            = 1'b0;
    logic        o_valid;
    logic        i_stall              = 1'b0;
    logic        o_blocked;
    logic [2:0]  o_category;

    t_verdict    verdicts_due [$];
    t_verdict    head_due;
    logic        allow_lb_shadow = 1'b0;
    int unsigned err_count       = 0;
    int unsigned cycle_count     = 0;
    int unsigned burst_left      = 0;
    int unsigned stall_left      = 0;
    int unsigned stall_mode      = 0;

    ip_egress_address_blocker uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_allow_loopback (i_cfg_allow_loopback),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_addr_high          (i_addr_high),
        .i_addr_low           (i_addr_low),
        .i_is_ipv6            (i_is_ipv6),
        .i_is_null            (i_is_null),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_blocked            (o_blocked),
        .o_category           (o_category)
    );

    always #10 i_clk = ~i_clk;

    function automatic bit in_prefix(input logic [31:0] a, input t_v4_prefix p);
        return (a >> (32 - p.len)) == (p.net >> (32 - p.len));
    endfunction

    function automatic t_category v4_category(input logic [31:0] a);
        if (a[31:24] == 8'h7F) return CAT_LOOPBACK;
        if (&a || a[31:28] == 4'hE) return CAT_CASTING;
        if (a == 32'h0) return CAT_UNSPEC;
        if (a[31:16] == 16'hA9FE) return CAT_LOCAL;
        foreach (v4_reserved[i]) begin
            if (in_prefix(a, v4_reserved[i])) return CAT_SPECIAL;
        end
        return CAT_PUBLIC;
    endfunction

    function automatic t_category v6_category(input logic [63:0] hi, input logic [63:0] lo);
        if (hi == 64'h0 && lo == 64'h1) return CAT_LOOPBACK;
        if (hi[63:56] == 8'hFF) return CAT_CASTING;
        if (hi == 64'h0 && lo == 64'h0) return CAT_UNSPEC;
        // fe80::/10, fec0::/10, fc00::/7
        if (hi[63:54] == 10'b11_1111_1010 || hi[63:54] == 10'b11_1111_1011) return CAT_LOCAL;
        if (hi[63:57] == 7'b111_1110) return CAT_LOCAL;
        // tunnel wrappers take the verdict of the carried ipv4 address
        if (hi[63:48] == PFX_6TO4) return v4_category(hi[47:16]);
        if (hi[63:32] == PFX_TEREDO) return v4_category(~lo[31:0]);
        if (hi == PFX_NAT64 && lo[63:32] == 32'h0) return v4_category(lo[31:0]);
        if (hi == PFX_DISCARD || hi[63:32] == PFX_DOC) return CAT_SPECIAL;
        return CAT_PUBLIC;
    endfunction

    function automatic t_verdict egress_verdict(input logic [63:0] hi, input logic [63:0] lo,
                                                input logic v6, input logic nul);
        t_verdict v;
        if (nul) begin
            v.cat = CAT_NULL;
        end else if (!v6 || (hi == 64'h0 && lo[63:32] == MAPPED_UPPER)) begin
            v.cat = v4_category(lo[31:0]);
        end else begin
            v.cat = v6_category(hi, lo);
        end
        v.blocked = (v.cat == CAT_LOOPBACK) ? !allow_lb_shadow : (v.cat != CAT_PUBLIC);
        return v;
    endfunction

    // mostly addresses inside the interesting blocks, some fully random, some one bit off
    function automatic logic [31:0] random_v4();
        logic [31:0] a;
        logic [31:0] mask;
        t_v4_prefix  p;
        a = $urandom;
        if ($urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 1) != 0) begin
                p = v4_reserved[$urandom_range(0, 10)];
            end else begin
                p = v4_scoped[$urandom_range(0, 4)];
            end
            mask = ~(32'hFFFF_FFFF >> p.len);
            a = (p.net & mask) | (a & ~mask);
        end
        if ($urandom_range(0, 7) == 0) begin
            a = a ^ (32'h1 << $urandom_range(0, 31));
        end
        return a;
    endfunction

    task automatic make_random_word(output logic [63:0] hi, output logic [63:0] lo,
                                    output logic v6, output logic nul);
        logic [31:0] v4;
        v4  = random_v4();
        hi  = {$urandom, $urandom};
        lo  = {$urandom, $urandom};
        nul = ($urandom_range(0, 15) == 0);
        v6  = 1'($urandom_range(0, 1));
        if (!v6) begin
            lo[31:0] = v4;
            if ($urandom_range(0, 1) != 0) begin
                hi = 64'h0;
                lo[63:32] = 32'h0;
            end
        end else begin
            case ($urandom_range(0, 13))
                0: ;
                1: begin
                    hi = 64'h0;
                    lo = 64'($urandom_range(0, 3));
                end
                2: hi[63:56] = 8'hFF;
                3: hi[63:54] = 10'b11_1111_1010;
                4: hi[63:54] = 10'b11_1111_1011;
                5: hi[63:57] = 7'b111_1110;
                6: hi[63:16] = {PFX_6TO4, v4};
                7: begin
                    hi[63:32] = PFX_TEREDO;
                    lo[31:0]  = ~v4;
                end
                8: begin
                    hi = PFX_NAT64;
                    lo = {($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'h0, v4};
                end
                9: hi = PFX_DISCARD;
                10: hi[63:32] = PFX_DOC;
                11, 12: begin
                    hi = 64'h0;
                    lo = {MAPPED_UPPER, v4};
                end
                default: begin
                    // near the mapped form
                    hi = 64'h0;
                    lo = {32'($urandom_range(32'h0000_FFFE, 32'h0001_0000)), v4};
                end
            endcase
            if ($urandom_range(0, 9) == 0) begin
                hi = hi ^ (64'h1 << $urandom_range(0, 63));
            end
        end
    endtask

    task automatic push_word(input logic [63:0] hi, input logic [63:0] lo, input logic v6,
                             input logic nul, input bit use_typed, input t_verdict typed_v);
        int unsigned gap;
        i_valid     <= 1'b1;
        i_addr_high <= hi;
        i_addr_low  <= lo;
        i_is_ipv6   <= v6;
        i_is_null   <= nul;
        do @(posedge i_clk); while (o_stall);
        verdicts_due.push_back(use_typed ? typed_v : egress_verdict(hi, lo, v6, nul));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic wait_verdicts_drained();
        i_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_allow_loopback(input logic value);
        wait_verdicts_drained();
        i_cfg_allow_loopback <= value;
        i_cfg_valid          <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid     <= 1'b0;
        allow_lb_shadow  = value;
    endtask

    // downstream stall: free run, light, heavy, or a square-wave pattern from bit 2 of the cycle counter
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 3) != 0);
            default: i_stall <= cycle_count[2];
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (verdicts_due.size() == 0) begin
                $error("verdict word with nothing expected: blocked %0b, category %0d",
                       o_blocked, o_category);
                err_count++;
            end else begin
                head_due = verdicts_due.pop_front();
                if (o_blocked !== head_due.blocked) begin
                    $error("blocked: expected %0b, got %0b", head_due.blocked, o_blocked);
                    err_count++;
                end
                if (o_category !== head_due.cat) begin
                    $error("category: expected %0d, got %0d", head_due.cat, o_category);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        logic [63:0] hi;
        logic [63:0] lo;
        logic        v6;
        logic        nul;
        t_verdict    no_typed;
        no_typed = '{1'b0, CAT_PUBLIC};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table: first with loopback at its reset value, then with it allowed
        for (int pass = 0; pass < 2; pass++) begin
            if (pass == 1) begin
                write_allow_loopback(1'b1);
            end
            foreach (dir_rows[r]) begin
                push_word(dir_rows[r].hi, dir_rows[r].lo, dir_rows[r].v6, dir_rows[r].nul,
                          dir_rows[r].typed && pass == 0,
                          '{dir_rows[r].blk, dir_rows[r].cat});
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            write_allow_loopback(ph[0]);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (n == PHASE_WORDS / 2) begin
                    wait_verdicts_drained();
                end
                make_random_word(hi, lo, v6, nul);
                push_word(hi, lo, v6, nul, 1'b0, no_typed);
            end
        end

        wait_verdicts_drained();
        repeat (8) @(posedge i_clk);
        if (err_count == 0 && verdicts_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
